@@ rtl/brsm_pkg.sv @@
// Block range state map: shared package.
// Holds opcodes, state codes, field widths and the controller/datapath structs.
// No dependencies.
package brsm_pkg;

    localparam int BLK_W     = 48;
    localparam int CNT_W     = 32;
    localparam int CODE_W    = 3;
    localparam int TOT_W     = 64;
    localparam int USE_W     = 9;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_LOOK  = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    localparam logic [CODE_W-1:0] STATE_ABSENT = 3'd4;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic chk;
        logic rd;
        logic push_left;
        logic push_right;
        logic skip;
        logic gen_step;
        logic scan_rst;
        logic hold_right;
        logic res1;
        logic res2;
        logic res3;
        logic flush;
        logic set_hit;
        logic fin;
    } t_dp_cmd;

    // Flags from the datapath to the sequencer
    typedef struct packed {
        logic [1:0] op;
        logic       c_zero;
        logic       too_many;
        logic       idx_end;
        logic       is_left;
        logic       is_right;
        logic       hit;
        logic       gen_done;
        logic       qv;
        logic       out_free;
    } t_dp_sts;

endpackage

@@ rtl/brsm_ctrl.sv @@
// Block range state map: sequencer state machine.
// Drives brsm_dp through t_dp_cmd and reacts to t_dp_sts; uses brsm_pkg.
module brsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  brsm_pkg::t_dp_sts i_sts,
    output brsm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_CHK   = 14'b00000000000100,
        S_LRD   = 14'b00000000001000,
        S_LEV   = 14'b00000000010000,
        S_GEN   = 14'b00000000100000,
        S_RRD   = 14'b00000001000000,
        S_REV   = 14'b00000010000000,
        S_RES1  = 14'b00000100000000,
        S_RES2  = 14'b00001000000000,
        S_RES3  = 14'b00010000000000,
        S_FLUSH = 14'b00100000000000,
        S_QEV   = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_look_rd;

    // Hold the state; r_look_rd flags that the state is S_QEV
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_look_rd <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_look_rd <= (n_state == S_QEV);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command strobes
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.op == brsm_pkg::OP_MARK) begin
                    n_state = i_sts.c_zero ? S_FIN : S_CHK;
                end else if (i_sts.op == brsm_pkg::OP_LOOK) begin
                    if (i_sts.idx_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_QEV;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.too_many ? S_FIN : S_LRD;
            end
            S_LRD: begin
                if (i_sts.idx_end) begin
                    n_state = S_GEN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LEV;
                end
            end
            S_LEV: begin
                if (i_sts.is_left) begin
                    o_cmd.push_left = 1'b1;
                    n_state         = S_LRD;
                end else begin
                    n_state = S_GEN;
                end
            end
            S_GEN: begin
                if (i_sts.gen_done) begin
                    o_cmd.scan_rst = 1'b1;
                    n_state        = S_RRD;
                end else begin
                    o_cmd.gen_step = 1'b1;
                end
            end
            S_RRD: begin
                if (i_sts.idx_end) begin
                    n_state = i_sts.qv ? S_RES1 : S_FLUSH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_REV;
                end
            end
            S_REV: begin
                if (!i_sts.is_right) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_RRD;
                end else if (i_sts.qv) begin
                    o_cmd.hold_right = 1'b1;
                    n_state          = S_RES1;
                end else begin
                    o_cmd.push_right = 1'b1;
                    n_state          = S_RRD;
                end
            end
            S_RES1: begin
                o_cmd.res1 = 1'b1;
                n_state    = S_RES2;
            end
            S_RES2: begin
                o_cmd.res2 = 1'b1;
                n_state    = S_RES3;
            end
            S_RES3: begin
                o_cmd.res3 = 1'b1;
                n_state    = S_RRD;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_FIN;
            end
            S_QEV: begin
                // Read data for the entry issued last cycle is here
                if (r_look_rd && i_sts.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/brsm_dp.sv @@
// Block range state map: datapath.
// Run table (two banks in one memory), rebuild buffers, totals and result register.
// Uses brsm_pkg; controlled by brsm_ctrl.
module brsm_dp #(
    parameter int          MAX_RUNS       = 256,
    parameter int unsigned RUN_LENGTH_MAX = 65535
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  brsm_pkg::t_dp_cmd                    i_cmd,
    output brsm_pkg::t_dp_sts                    o_sts,
    input  logic [1:0]                           i_opcode,
    input  logic [brsm_pkg::BLK_W-1:0]           i_start_block,
    input  logic [brsm_pkg::CNT_W-1:0]           i_block_count,
    input  logic [brsm_pkg::CODE_W-1:0]          i_state_code,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_status,
    output logic [brsm_pkg::CODE_W-1:0]          o_block_state,
    output logic [brsm_pkg::TOT_W-1:0]           o_block_total,
    output logic [brsm_pkg::USE_W-1:0]           o_entries_in_use
);

    localparam int BW    = brsm_pkg::BLK_W;
    localparam int IW    = $clog2(MAX_RUNS);
    localparam int CW    = $clog2(MAX_RUNS + 1);
    localparam int LW    = $clog2(64'(RUN_LENGTH_MAX) + 64'd1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [LW-1:0] LIM  = LW'(RUN_LENGTH_MAX);
    localparam logic [63:0]   KMAX = 64'(MAX_RUNS) * 64'(RUN_LENGTH_MAX);
    localparam logic [BW:0]   SPAN = {1'b1, {BW{1'b0}}};

    // Run table: bank r_bank is live, the other is rebuilt during a mark
    logic [BW-1:0] mem_start [DEPTH];
    logic [LW-1:0] mem_len   [DEPTH];
    logic [1:0]    mem_st    [DEPTH];

    logic [BW-1:0] r_rd_start;
    logic [LW-1:0] r_rd_len;
    logic [1:0]    r_rd_st;

    // Item registers
    logic [1:0]                  r_op;
    logic [BW-1:0]               r_s;
    logic [brsm_pkg::CNT_W-1:0]  r_c;
    logic [brsm_pkg::CODE_W-1:0] r_code;
    logic [BW:0]                 r_e;
    logic [BW-1:0]               r_pos;
    logic [brsm_pkg::CNT_W-1:0]  r_rem;
    logic [brsm_pkg::CODE_W-1:0] r_hit_st;

    // Control registers
    logic [CW-1:0] r_idx, r_w, r_cnt;
    logic          r_bank, r_pv, r_qv, r_xv, r_ovf, r_commit, r_ovalid;
    logic [brsm_pkg::TOT_W-1:0] r_tot [4];
    logic [brsm_pkg::TOT_W-1:0] r_acc [4];

    // Pending run P, last new run Q, first right run X
    logic [BW-1:0] r_p_start, r_q_start, r_x_start;
    logic [LW-1:0] r_p_len, r_q_len, r_x_len;
    logic [1:0]    r_p_st, r_q_st, r_x_st;

    // Result register
    logic                        r_o_status;
    logic [brsm_pkg::CODE_W-1:0] r_o_bstate;
    logic [brsm_pkg::TOT_W-1:0]  r_o_total;
    logic [brsm_pkg::USE_W-1:0]  r_o_count;

    logic [BW:0]   rd_end, right_a, rem_sp;
    logic [LW-1:0] left_len, right_len;
    logic          m_qx, m_pq, gen_last, wr_en, wr_full, push_en, commit_ok;
    logic [BW-1:0] px_start;
    logic [LW-1:0] px_len;
    logic [1:0]    px_st;

    // Trim the entry just read against the marked range
    always_comb begin
        rd_end    = {1'b0, r_rd_start} + (BW + 1)'(r_rd_len);
        left_len  = (rd_end < {1'b0, r_s}) ? r_rd_len : LW'(r_s - r_rd_start);
        right_a   = ({1'b0, r_rd_start} > r_e) ? {1'b0, r_rd_start} : r_e;
        right_len = LW'(rd_end - right_a);
        rem_sp    = SPAN - {1'b0, r_s};
        gen_last  = ({1'b0, r_rem} <= (brsm_pkg::CNT_W + 1)'(LIM));
        m_qx = ({1'b0, r_q_start} + (BW + 1)'(r_q_len) == {1'b0, r_x_start})
            && (r_q_st == r_x_st)
            && ((LW + 1)'(r_q_len) + (LW + 1)'(r_x_len) <= (LW + 1)'(LIM));
        m_pq = ({1'b0, r_p_start} + (BW + 1)'(r_p_len) == {1'b0, r_q_start})
            && (r_p_st == r_q_st)
            && ((LW + 1)'(r_p_len) + (LW + 1)'(r_q_len) <= (LW + 1)'(LIM));
    end

    // Select the run pushed behind P
    always_comb begin
        push_en  = 1'b0;
        px_start = r_x_start;
        px_len   = r_x_len;
        px_st    = r_x_st;
        if (i_cmd.push_left) begin
            push_en  = 1'b1;
            px_start = r_rd_start;
            px_len   = left_len;
            px_st    = r_rd_st;
        end else if (i_cmd.push_right) begin
            push_en  = 1'b1;
            px_start = right_a[BW-1:0];
            px_len   = right_len;
            px_st    = r_rd_st;
        end else if (i_cmd.gen_step && !gen_last) begin
            push_en  = 1'b1;
            px_start = r_pos;
            px_len   = LIM;
            px_st    = r_code[1:0];
        end else if (i_cmd.res3 && r_xv) begin
            push_en = 1'b1;
        end
    end

    assign wr_en = r_pv && (push_en || i_cmd.flush || (i_cmd.res2 && !m_pq));
    assign wr_full   = (r_w == CW'(MAX_RUNS));
    assign commit_ok = r_commit && !r_ovf;

    // Table memory: write the rebuild bank, read the live bank
    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_full) begin
            mem_start[{~r_bank, r_w[IW-1:0]}] <= r_p_start;
            mem_len[{~r_bank, r_w[IW-1:0]}]   <= r_p_len;
            mem_st[{~r_bank, r_w[IW-1:0]}]    <= r_p_st;
        end
        if (i_cmd.rd) begin
            r_rd_start <= mem_start[{r_bank, r_idx[IW-1:0]}];
            r_rd_len   <= mem_len[{r_bank, r_idx[IW-1:0]}];
            r_rd_st    <= mem_st[{r_bank, r_idx[IW-1:0]}];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_w      <= '0;
            r_cnt    <= '0;
            r_bank   <= 1'b0;
            r_pv     <= 1'b0;
            r_qv     <= 1'b0;
            r_xv     <= 1'b0;
            r_ovf    <= 1'b0;
            r_commit <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_tot[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_w      <= '0;
                r_pv     <= 1'b0;
                r_qv     <= 1'b0;
                r_xv     <= 1'b0;
                r_ovf    <= 1'b0;
                r_commit <= 1'b0;
            end
            // Only a present state is cut into runs that can exceed the table
            if (i_cmd.chk && !r_code[2] && (64'(r_c) > KMAX)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.scan_rst) begin
                r_idx <= '0;
            end
            if (i_cmd.push_left || i_cmd.push_right || i_cmd.skip || i_cmd.hold_right) begin
                r_idx <= r_idx + CW'(1);
            end
            if (push_en) begin
                r_pv <= 1'b1;
            end
            if (i_cmd.gen_step && gen_last) begin
                r_qv <= 1'b1;
            end
            if (i_cmd.hold_right) begin
                r_xv <= 1'b1;
            end
            if (i_cmd.res1 && m_qx) begin
                r_xv <= 1'b0;
            end
            if (i_cmd.res2) begin
                r_pv <= 1'b1;
                r_qv <= 1'b0;
            end
            if (i_cmd.res3) begin
                r_xv <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_pv     <= 1'b0;
                r_commit <= 1'b1;
            end
            if (wr_en) begin
                if (wr_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_w <= r_w + CW'(1);
                end
            end
            // Drop the result once taken; a fresh one overrides
            if (i_cmd.fin) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.fin) begin
                if (commit_ok) begin
                    r_bank <= ~r_bank;
                    r_cnt  <= r_w;
                    for (int k = 0; k < 4; k++) begin
                        r_tot[k] <= r_acc[k];
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_s      <= i_start_block;
            r_c      <= i_block_count;
            r_code   <= i_state_code;
            r_hit_st <= brsm_pkg::STATE_ABSENT;
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= '0;
            end
        end
        // Clip the range at the end of the block space
        if (i_cmd.prep && ({{(BW + 1 - brsm_pkg::CNT_W){1'b0}}, r_c} > rem_sp)) begin
            r_c <= rem_sp[brsm_pkg::CNT_W-1:0];
        end
        if (i_cmd.chk) begin
            r_e   <= {1'b0, r_s} + (BW + 1)'(r_c);
            r_pos <= r_s;
            r_rem <= r_c;
        end
        if (push_en) begin
            r_p_start <= px_start;
            r_p_len   <= px_len;
            r_p_st    <= px_st;
        end
        // Cut one new run off the range; hold the last one in Q
        if (i_cmd.gen_step) begin
            if (gen_last) begin
                r_q_start <= r_pos;
                r_q_len   <= LW'(r_rem);
                r_q_st    <= r_code[1:0];
                r_rem     <= '0;
            end else begin
                r_pos <= r_pos + BW'(LIM);
                r_rem <= r_rem - brsm_pkg::CNT_W'(LIM);
            end
        end
        if (i_cmd.hold_right) begin
            r_x_start <= right_a[BW-1:0];
            r_x_len   <= right_len;
            r_x_st    <= r_rd_st;
        end
        // Join Q with the run after it, then P with Q
        if (i_cmd.res1 && r_xv && m_qx) begin
            r_q_len <= r_q_len + r_x_len;
        end
        if (i_cmd.res2) begin
            if (r_pv && m_pq) begin
                r_p_len <= r_p_len + r_q_len;
            end else begin
                r_p_start <= r_q_start;
                r_p_len   <= r_q_len;
                r_p_st    <= r_q_st;
            end
        end
        if (wr_en && !wr_full) begin
            r_acc[r_p_st] <= r_acc[r_p_st] + brsm_pkg::TOT_W'(r_p_len);
        end
        if (i_cmd.set_hit) begin
            r_hit_st <= {1'b0, r_rd_st};
        end
        if (i_cmd.fin) begin
            r_o_status <= r_ovf;
            r_o_bstate <= (r_op == brsm_pkg::OP_LOOK) ? r_hit_st : '0;
            if (r_op != brsm_pkg::OP_COUNT) begin
                r_o_total <= '0;
            end else if (r_code[2]) begin
                r_o_total <= '1;
            end else begin
                r_o_total <= r_tot[r_code[1:0]];
            end
            r_o_count <= brsm_pkg::USE_W'(commit_ok ? r_w : r_cnt);
        end
    end

    // Flags to the sequencer
    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.c_zero   = (r_c == '0);
        o_sts.too_many = !r_code[2] && (64'(r_c) > KMAX);
        o_sts.idx_end  = (r_idx == r_cnt);
        o_sts.is_left  = (r_rd_start < r_s);
        o_sts.is_right = (rd_end > r_e);
        o_sts.hit      = (r_rd_start <= r_s) && (rd_end > {1'b0, r_s});
        o_sts.gen_done = r_code[2] || (r_rem == '0);
        o_sts.qv       = r_qv;
        o_sts.out_free = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_o_status;
    assign o_block_state    = r_o_bstate;
    assign o_block_total    = r_o_total;
    assign o_entries_in_use = r_o_count;

endmodule

@@ rtl/block_range_state_map_unit.sv @@
// Block range state map: top level.
// Instantiates brsm_ctrl and brsm_dp; uses brsm_pkg.
//
// Keeps up to MAX_RUNS sorted block runs (start, length, one of four states)
// plus a block total per state. One item is worked at a time. A count item
// needs no table read; a lookup reads the stored runs in turn until one
// holds the block or none is left. A mark rebuilds the table into the
// spare bank of a single-port-read table memory: a left scan over the
// stored runs, then the new runs, then a right scan. A mark that would
// overflow the table is dropped with status 1 and leaves table and totals
// untouched. The input stall is high from acceptance until the result is
// registered; a finished result may wait on the output while the next item
// is taken.
module block_range_state_map_unit #(
    parameter int          MAX_RUNS       = 256,
    parameter int unsigned RUN_LENGTH_MAX = 65535
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_opcode,
    input  logic [brsm_pkg::BLK_W-1:0]           i_start_block,
    input  logic [brsm_pkg::CNT_W-1:0]           i_block_count,
    input  logic [brsm_pkg::CODE_W-1:0]          i_state_code,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_status,
    output logic [brsm_pkg::CODE_W-1:0]          o_block_state,
    output logic [brsm_pkg::TOT_W-1:0]           o_block_total,
    output logic [brsm_pkg::USE_W-1:0]           o_entries_in_use
);

    brsm_pkg::t_dp_cmd cmd;
    brsm_pkg::t_dp_sts sts;

    brsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brsm_dp #(
        .MAX_RUNS       (MAX_RUNS),
        .RUN_LENGTH_MAX (RUN_LENGTH_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_start_block    (i_start_block),
        .i_block_count    (i_block_count),
        .i_state_code     (i_state_code),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_block_state    (o_block_state),
        .o_block_total    (o_block_total),
        .o_entries_in_use (o_entries_in_use)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for block_range_state_map_unit: directed and random beats,
// checked against an in-bench run-table predictor held in a scoreboard class.
// Depends on rtl/brsm_pkg.sv and rtl/block_range_state_map_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUNS = 256;
    localparam int unsigned RUN_LENGTH_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic                        status;
        logic [brsm_pkg::CODE_W-1:0] block_state;
        logic [brsm_pkg::TOT_W-1:0]  block_total;
        logic [brsm_pkg::USE_W-1:0]  entries_in_use;
    } t_run_map_result;

    // Predictor of the run table plus the queue of results it expects
    class run_map_board;
        logic [brsm_pkg::BLK_W-1:0] run_start [MAX_RUNS];
        logic [63:0]      run_len [MAX_RUNS];
        logic [1:0]       run_st [MAX_RUNS];
        int               run_cnt;
        logic [63:0]      totals [4];
        logic [63:0]      tmp_start [2*MAX_RUNS+2];
        logic [63:0]      tmp_len [2*MAX_RUNS+2];
        logic [1:0]       tmp_st [2*MAX_RUNS+2];
        int               tmp_n;
        t_run_map_result  pending_results [$];
        int               error_count;

        function new();
            run_cnt = 0;
            tmp_n = 0;
            error_count = 0;
            foreach (totals[i]) totals[i] = '0;
        endfunction

        function void put_run(logic [63:0] a, logic [63:0] len, logic [2:0] st);
            if (tmp_n >= 2*MAX_RUNS+2 || len == 0) return;
            tmp_start[tmp_n] = a;
            tmp_len[tmp_n] = len;
            tmp_st[tmp_n] = st[1:0];
            tmp_n++;
        endfunction

        // Fold run i+1 into run i when touching, equal and within the limit
        function void join_runs(int i);
            if (i + 1 >= tmp_n) return;
            if (tmp_start[i] + tmp_len[i] != tmp_start[i+1] || tmp_st[i] != tmp_st[i+1])
                return;
            if (tmp_len[i] + tmp_len[i+1] > RUN_LENGTH_MAX) return;
            tmp_len[i] += tmp_len[i+1];
            for (int j = i + 1; j + 1 < tmp_n; j++) begin
                tmp_start[j] = tmp_start[j+1];
                tmp_len[j] = tmp_len[j+1];
                tmp_st[j] = tmp_st[j+1];
            end
            tmp_n--;
        endfunction

        function logic mark_range(logic [63:0] s, logic [63:0] c, logic [2:0] code);
            logic [63:0] span_end, e, k, a, b, a2, off;
            logic        present;
            int          left, p;
            span_end = 64'd1 << brsm_pkg::BLK_W;
            k = 0;
            present = code < brsm_pkg::STATE_ABSENT;
            if (c == 0) return 1'b0;
            if (c > span_end - s) c = span_end - s;
            e = s + c;
            if (present) begin
                k = (c + RUN_LENGTH_MAX - 1) / RUN_LENGTH_MAX;
                if (k > MAX_RUNS) return 1'b1;
            end
            tmp_n = 0;
            // keep what lies left of the range
            for (int i = 0; i < run_cnt; i++) begin
                a = run_start[i];
                b = a + run_len[i];
                if (a < s) put_run(a, (b < s ? b : s) - a, {1'b0, run_st[i]});
            end
            left = tmp_n;
            for (int j = 0; j < k; j++) begin
                off = j * RUN_LENGTH_MAX;
                put_run(s + off, (j + 1 == k) ? c - off : RUN_LENGTH_MAX, code);
            end
            // keep what lies right of the range
            for (int i = 0; i < run_cnt; i++) begin
                a = run_start[i];
                b = a + run_len[i];
                if (b > e) begin
                    a2 = a > e ? a : e;
                    put_run(a2, b - a2, {1'b0, run_st[i]});
                end
            end
            if (present) begin
                p = left + int'(k) - 1;
                join_runs(p);
                if (p >= 1) join_runs(p - 1);
            end
            if (tmp_n > MAX_RUNS) return 1'b1;
            foreach (totals[i]) totals[i] = '0;
            for (int i = 0; i < tmp_n; i++) begin
                run_start[i] = tmp_start[i][brsm_pkg::BLK_W-1:0];
                run_len[i] = tmp_len[i];
                run_st[i] = tmp_st[i];
                totals[tmp_st[i]] += tmp_len[i];
            end
            run_cnt = tmp_n;
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] op, logic [brsm_pkg::BLK_W-1:0] s,
                                logic [brsm_pkg::CNT_W-1:0] c,
                                logic [brsm_pkg::CODE_W-1:0] code);
            t_run_map_result r;
            r.status = 1'b0;
            r.block_state = '0;
            r.block_total = '0;
            if (op == brsm_pkg::OP_MARK) begin
                r.status = mark_range({16'd0, s}, {32'd0, c}, code);
            end else if (op == brsm_pkg::OP_LOOK) begin
                r.block_state = brsm_pkg::STATE_ABSENT;
                for (int i = 0; i < run_cnt; i++) begin
                    if ({16'd0, run_start[i]} <= {16'd0, s} &&
                        {16'd0, run_start[i]} + run_len[i] > {16'd0, s}) begin
                        r.block_state = {1'b0, run_st[i]};
                        break;
                    end
                end
            end else if (op == brsm_pkg::OP_COUNT) begin
                r.block_total = code < brsm_pkg::STATE_ABSENT ? totals[code[1:0]] : '1;
            end
            r.entries_in_use = run_cnt[brsm_pkg::USE_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic st, logic [brsm_pkg::CODE_W-1:0] bs,
                                   logic [brsm_pkg::TOT_W-1:0] tot,
                                   logic [brsm_pkg::USE_W-1:0] used);
            t_run_map_result r;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                error_count++;
                return;
            end
            r = pending_results.pop_front();
            if (st !== r.status) begin
                $display("%0t: status exp %0d got %0d", $time, r.status, st);
                error_count++;
            end
            if (bs !== r.block_state) begin
                $display("%0t: block_state exp %0d got %0d", $time, r.block_state, bs);
                error_count++;
            end
            if (tot !== r.block_total) begin
                $display("%0t: block_total exp %0h got %0h", $time, r.block_total, tot);
                error_count++;
            end
            if (used !== r.entries_in_use) begin
                $display("%0t: entries_in_use exp %0d got %0d", $time,
                         r.entries_in_use, used);
                error_count++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_opcode = '0;
    logic [brsm_pkg::BLK_W-1:0]  i_start_block = '0;
    logic [brsm_pkg::CNT_W-1:0]  i_block_count = '0;
    logic [brsm_pkg::CODE_W-1:0] i_state_code = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_status;
    logic [brsm_pkg::CODE_W-1:0] o_block_state;
    logic [brsm_pkg::TOT_W-1:0]  o_block_total;
    logic [brsm_pkg::USE_W-1:0]  o_entries_in_use;

    run_map_board board = new();
    bit   quiet_phase = 1'b0;
    int   idle_cycles = 0;

    block_range_state_map_unit #(
        .MAX_RUNS(MAX_RUNS),
        .RUN_LENGTH_MAX(RUN_LENGTH_MAX)
    ) u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_status, o_block_state, o_block_total, o_entries_in_use);
    end

    // Stall the result side in random bursts
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 6);
                i_out_stall = 1'b1;
                repeat (burst) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Present one beat, hold it until taken, then maybe pause
    task automatic send_item(logic [1:0] op, logic [brsm_pkg::BLK_W-1:0] s,
                             logic [brsm_pkg::CNT_W-1:0] c,
                             logic [brsm_pkg::CODE_W-1:0] code);
        i_in_valid = 1'b1;
        i_opcode = op;
        i_start_block = s;
        i_block_count = c;
        i_state_code = code;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(op, s, c, code);
        @(negedge i_clk);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (board.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Random beat, mostly inside a small window so runs collide and merge
    task automatic send_random_item();
        logic [1:0]                  op;
        logic [brsm_pkg::BLK_W-1:0]  s;
        logic [brsm_pkg::CNT_W-1:0]  c;
        logic [brsm_pkg::CODE_W-1:0] code;
        logic [63:0]                 wide;
        int                          pick;
        pick = $urandom_range(0, 99);
        op = pick < 55 ? brsm_pkg::OP_MARK : pick < 80 ? brsm_pkg::OP_LOOK :
             pick < 95 ? brsm_pkg::OP_COUNT : 2'd3;
        wide = {$urandom, $urandom};
        s = ($urandom_range(0, 9) == 0) ? wide[brsm_pkg::BLK_W-1:0] :
            brsm_pkg::BLK_W'(1000 + $urandom_range(0, 1500));
        pick = $urandom_range(0, 99);
        c = pick < 85 ? $urandom_range(1, 20) : pick < 90 ? 0 :
            pick < 95 ? $urandom_range(1, 200000) : $urandom;
        code = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7)) :
               3'($urandom_range(0, 3));
        send_item(op, s, c, code);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, every opcode, range edges, merges, overflow
        send_item(brsm_pkg::OP_LOOK, '0, '0, '0);
        for (int st = 0; st < 8; st += 1) send_item(brsm_pkg::OP_COUNT, '0, '0, 3'(st));
        send_item(2'd3, '1, '1, 3'd7);
        send_item(brsm_pkg::OP_MARK, 48'd50, '0, 3'd1);
        send_item(brsm_pkg::OP_MARK, '1, '1, 3'd1);
        send_item(brsm_pkg::OP_MARK, '0, 256 * RUN_LENGTH_MAX, 3'd2);
        send_item(brsm_pkg::OP_MARK, '0, 255 * RUN_LENGTH_MAX, 3'd2);
        send_item(brsm_pkg::OP_MARK, 48'd70000, 32'd10, 3'd5);
        send_item(brsm_pkg::OP_MARK, '0, '1, brsm_pkg::STATE_ABSENT);
        send_item(brsm_pkg::OP_MARK, 48'd100, 32'd10, 3'd0);
        send_item(brsm_pkg::OP_MARK, 48'd110, 32'd10, 3'd0);
        send_item(brsm_pkg::OP_MARK, 48'd90, 32'd10, 3'd0);
        send_item(brsm_pkg::OP_MARK, 48'd95, 32'd3, 3'd3);
        send_item(brsm_pkg::OP_LOOK, 48'd96, '0, '0);
        send_item(brsm_pkg::OP_LOOK, '1, '0, '0);
        send_item(brsm_pkg::OP_COUNT, '0, '0, 3'd0);
        send_item(brsm_pkg::OP_MARK, 48'd98, 32'd4, 3'd7);

        repeat (180) send_random_item();
        drain_results();

        // Fill the table with isolated single blocks until it overflows
        for (int i = 0; i < 270; i++) begin
            send_item(brsm_pkg::OP_MARK, 48'd5000 + brsm_pkg::BLK_W'(2 * i), 32'd1,
                      3'(i % 4));
            if (i % 16 == 0) send_random_item();
        end

        quiet_phase = 1'b1;
        repeat (160) send_random_item();
        drain_results();
        repeat (50) @(negedge i_clk);
        if (board.error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
